/* rtl/core/slids_pkg.sv */
// shared types and constants for the sorted leaf core
// holds the record layout, leaf sizing and result status codes; no dependencies
package slids_pkg;

  localparam int CAPACITY = 32;
  localparam int NCELL    = CAPACITY + 1;
  localparam int KEEP     = (CAPACITY + 1) / 2;
  localparam int NMOVE    = NCELL - KEEP;

  localparam int KEY_W = 64;
  localparam int RID_W = 31;
  localparam int CNT_W = 6;
  localparam int ST_W  = 3;

  localparam logic [ST_W-1:0] STATUS_INSERTED  = 3'd0;
  localparam logic [ST_W-1:0] STATUS_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] STATUS_DELETED   = 3'd2;
  localparam logic [ST_W-1:0] STATUS_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] STATUS_SPLIT     = 3'd4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef struct packed {
    logic [RID_W-1:0] slot;
    logic [RID_W-1:0] page;
    logic [KEY_W-1:0] key;
  } rec_t;

  // per-cell controls for one cycle
  typedef struct packed {
    logic cmp;    // latch compare flags against the request
    logic ins;    // insert step: hold, take request or take left neighbor
    logic del;    // delete step: hold or take right neighbor
    logic shift;  // split emission: take right neighbor
  } cell_ctl_t;

endpackage

/* rtl/core/slids_cell.sv */
// one record cell of the leaf row: record register, compare and shift mux
// depends on slids_pkg
module slids_cell
  import slids_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      occ_i,
  input  logic      lt_left_i,
  input  rec_t      req_i,
  input  rec_t      left_i,
  input  rec_t      right_i,
  output rec_t      rec_o,
  output logic      lt_o,
  output logic      eq_o
);

  rec_t rec_q, rec_d;
  logic lt_q, lt_d, eq_q, eq_d;
  logic less_w, same_w;

  always_comb begin
    less_w = (rec_q.key < req_i.key) ||
             ((rec_q.key == req_i.key) && (rec_q.page < req_i.page)) ||
             ((rec_q.key == req_i.key) && (rec_q.page == req_i.page) &&
              (rec_q.slot < req_i.slot));
    same_w = (rec_q == req_i);
  end

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctl_i.cmp) begin
      lt_d = occ_i & less_w;
      eq_d = occ_i & same_w;
    end
  end

  // lt flags form a prefix, so the cell just past it is the lower bound
  always_comb begin
    rec_d = rec_q;
    if (ctl_i.ins) begin
      if (!lt_q) begin
        rec_d = lt_left_i ? req_i : left_i;
      end
    end else if (ctl_i.del) begin
      if (!lt_q) begin
        rec_d = right_i;
      end
    end else if (ctl_i.shift) begin
      rec_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  assign rec_o = rec_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

/* rtl/core/sorted_leaf_insert_delete_split_core.sv */
// top level of the sorted leaf core: stream ports, sequencer and the cell row
// depends on slids_pkg and slids_cell
//
// The leaf is a row of CAPACITY+1 record cells kept in ascending order of
// (key, page, slot). A request is taken, then every cell compares itself to
// it in the compare state, then every cell shifts or holds in the update
// state. An insert or delete writes its result to the output register in the
// update state, and the next request is taken back in the idle state; no new
// request is taken before the compare-then-shift pass through the cell row is
// done. An insert into a full leaf keeps the first (CAPACITY+1)/2 records and
// then sends out the remaining CAPACITY/2+1 records one per cycle from the
// middle cell while the output register is free, the last one marked with
// tlast. A new request is taken while the previous result still waits in the
// output register. Back pressure holds the update and emit states until
// the output register is free. The record cells need no clearing after reset:
// only cells below the record count are ever compared or sent.
module sorted_leaf_insert_delete_split_core
  import slids_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // key[63:0], rid_page[94:64], rid_slot[125:95], zero pad
  input  logic         s_axis_tuser,   // mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // status[2:0], count_after[8:3], moved_key[72:9],
                                       // moved_page[103:73], moved_slot[134:104], zero pad
  output logic         m_axis_tlast    // last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] left_q, left_d;
  rec_t             req_q;
  logic             mode_q;

  logic             out_valid_q, out_valid_d;
  logic [ST_W-1:0]  out_status_q, out_status_d;
  logic [CNT_W-1:0] out_count_q, out_count_d;
  rec_t             out_rec_q, out_rec_d;
  logic             out_last_q, out_last_d;

  rec_t             cell_rec_w [NCELL];
  logic [NCELL-1:0] lt_w, eq_w;
  logic             found_w, out_free_w, accept_w;
  logic             do_cmp, do_ins, do_del, do_shift;

  assign accept_w   = s_axis_tvalid && s_axis_tready;
  assign out_free_w = !out_valid_q || m_axis_tready;
  assign found_w    = |eq_w;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    left_d       = left_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_rec_d    = out_rec_q;
    out_last_d   = out_last_q;
    do_cmp       = 1'b0;
    do_ins       = 1'b0;
    do_del       = 1'b0;
    do_shift     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        do_cmp  = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free_w) begin
          out_rec_d  = '0;
          out_last_d = 1'b1;
          state_d    = ST_IDLE;
          if (mode_q == MODE_DELETE) begin
            out_valid_d = 1'b1;
            if (found_w) begin
              do_del       = 1'b1;
              count_d      = count_q - CNT_W'(1);
              out_status_d = STATUS_DELETED;
              out_count_d  = count_q - CNT_W'(1);
            end else begin
              out_status_d = STATUS_NOT_FOUND;
              out_count_d  = count_q;
            end
          end else if (found_w) begin
            out_valid_d  = 1'b1;
            out_status_d = STATUS_DUPLICATE;
            out_count_d  = count_q;
          end else if (count_q < CNT_W'(CAPACITY)) begin
            do_ins       = 1'b1;
            count_d      = count_q + CNT_W'(1);
            out_valid_d  = 1'b1;
            out_status_d = STATUS_INSERTED;
            out_count_d  = count_q + CNT_W'(1);
          end else begin
            // full leaf: insert into the spare cell, then send out the upper part
            do_ins  = 1'b1;
            count_d = CNT_W'(KEEP);
            left_d  = CNT_W'(NMOVE);
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free_w) begin
          do_shift     = 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = STATUS_SPLIT;
          out_count_d  = CNT_W'(KEEP);
          out_rec_d    = cell_rec_w[KEEP];
          out_last_d   = (left_q == CNT_W'(1));
          left_d       = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      req_q  <= s_axis_tdata[$bits(rec_t)-1:0];
      mode_q <= s_axis_tuser;
    end
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_rec_q    <= out_rec_d;
    out_last_q   <= out_last_d;
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    cell_ctl_t ctl;
    logic      occ;
    logic      lt_left;
    rec_t      left_rec, right_rec;

    assign ctl.cmp   = do_cmp;
    assign ctl.ins   = do_ins;
    assign ctl.del   = do_del;
    assign ctl.shift = do_shift && (i >= KEEP);
    assign occ       = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign lt_left  = 1'b1;
      assign left_rec = cell_rec_w[i];
    end else begin : g_inner
      assign lt_left  = lt_w[i-1];
      assign left_rec = cell_rec_w[i-1];
    end

    if (i == NCELL - 1) begin : g_end
      assign right_rec = cell_rec_w[i];
    end else begin : g_mid
      assign right_rec = cell_rec_w[i+1];
    end

    slids_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .occ_i     (occ),
      .lt_left_i (lt_left),
      .req_i     (req_q),
      .left_i    (left_rec),
      .right_i   (right_rec),
      .rec_o     (cell_rec_w[i]),
      .lt_o      (lt_w[i]),
      .eq_o      (eq_w[i])
    );
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_rec_q.slot, out_rec_q.page, out_rec_q.key,
                          out_count_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule
